>>> design/cfti_pkg.sv
// Shared constants, face codes and control types for cube face texel addressing.
package cfti_pkg;

   // Default sizes
   localparam int COORD_BITS_DEF    = 24;
   localparam int HALF_SIZE_MAX_DEF = 512;

   // Fixed field widths
   localparam int CSR_WIDTH   = 10;
   localparam int FACE_WIDTH  = 3;
   localparam int TEXEL_WIDTH = 10;

   localparam logic [CSR_WIDTH-1:0] HALF_SIZE_RESET = 10'd64;

   // Face codes
   localparam logic [FACE_WIDTH-1:0] FACE_POS_X = 3'd0;
   localparam logic [FACE_WIDTH-1:0] FACE_NEG_X = 3'd1;
   localparam logic [FACE_WIDTH-1:0] FACE_POS_Y = 3'd2;
   localparam logic [FACE_WIDTH-1:0] FACE_NEG_Y = 3'd3;
   localparam logic [FACE_WIDTH-1:0] FACE_POS_Z = 3'd4;
   localparam logic [FACE_WIDTH-1:0] FACE_NEG_Z = 3'd5;

   // Per-item control carried down the pipeline
   typedef struct packed {
      logic [FACE_WIDTH-1:0] face;
      logic                  degenerate;
      logic                  neg_col;
      logic                  neg_row;
   } ctl_type;

endpackage

>>> design/cfti_req_if.sv
// Input channel: eye and target points with valid/ready handshake.
interface cfti_req_if #(
   parameter int COORD_BITS = cfti_pkg::COORD_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] from_x;
   logic signed [COORD_BITS-1:0] from_y;
   logic signed [COORD_BITS-1:0] from_z;
   logic signed [COORD_BITS-1:0] target_x;
   logic signed [COORD_BITS-1:0] target_y;
   logic signed [COORD_BITS-1:0] target_z;

   modport source (
      output valid, from_x, from_y, from_z, target_x, target_y, target_z,
      input  ready
   );
   modport sink (
      input  valid, from_x, from_y, from_z, target_x, target_y, target_z,
      output ready
   );
endinterface

>>> design/cfti_rsp_if.sv
// Result channel: face, texel indices and degenerate flag with valid/ready handshake.
interface cfti_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [cfti_pkg::FACE_WIDTH-1:0]     face;
   logic [cfti_pkg::TEXEL_WIDTH-1:0]    texel_col;
   logic [cfti_pkg::TEXEL_WIDTH-1:0]    texel_row;
   logic                                degenerate;

   modport source (
      output valid, face, texel_col, texel_row, degenerate,
      input  ready
   );
   modport sink (
      input  valid, face, texel_col, texel_row, degenerate,
      output ready
   );
endinterface

>>> design/cube_face_texel_index.sv
// Top level: cube face and texel addressing pipeline with half size register.
//
//   channel  | dir | handshake       | contents
//   req_if   | in  | valid/ready     | from_x/y/z, target_x/y/z
//   rsp_if   | out | valid/ready     | face, texel_col, texel_row, degenerate
//   csr      | in  | csr_we          | csr_wdata = half_size
//
// One item per cycle sustained while rsp_if.ready holds; the pipeline is two front
// stages, one divider cell per quotient bit, and one result register.
// Synchronous active-high reset clears all valid bits; half_size returns to 64.
// Every stage holds its item while the one after it is full and stalled, so
// bubbles close up and input transfers continue while a result waits.
module cube_face_texel_index #(
   parameter int COORD_BITS    = cfti_pkg::COORD_BITS_DEF,
   parameter int HALF_SIZE_MAX = cfti_pkg::HALF_SIZE_MAX_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   cfti_req_if.sink                          req_if,
   cfti_rsp_if.source                        rsp_if,
   input  logic                              csr_we,
   input  logic [cfti_pkg::CSR_WIDTH-1:0]    csr_wdata
);
   import cfti_pkg::*;

   localparam int DW    = COORD_BITS + 1;
   localparam int HBITS = $clog2(HALF_SIZE_MAX + 1);
   localparam int NW    = DW + HBITS;
   localparam int QBITS = HBITS;

   logic [CSR_WIDTH-1:0] half_ff;
   logic [HBITS-1:0]     half_eff;

   logic             valid [QBITS+1];
   logic             ready [QBITS+1];
   ctl_type          ctl   [QBITS+1];
   logic [NW-1:0]    rcol  [QBITS+1];
   logic [NW-1:0]    rrow  [QBITS+1];
   logic [DW-1:0]    den   [QBITS+1];
   logic [QBITS-1:0] qcol  [QBITS+1];
   logic [QBITS-1:0] qrow  [QBITS+1];

   // Half size register
   always_ff @(posedge clock) begin
      if (reset) half_ff <= HALF_SIZE_RESET;
      else if (csr_we) half_ff <= csr_wdata;
   end

   // Zero acts as one, large values saturate
   always_comb begin
      if (half_ff == '0) half_eff = HBITS'(1);
      else if (32'(half_ff) > HALF_SIZE_MAX) half_eff = HBITS'(HALF_SIZE_MAX);
      else half_eff = HBITS'(half_ff);
   end

   cfti_front #(
      .COORD_BITS(COORD_BITS), .HALF_SIZE_MAX(HALF_SIZE_MAX),
      .DW(DW), .HBITS(HBITS), .NW(NW)
   ) u_front (
      .clock(clock), .reset(reset), .req(req_if), .half(half_eff),
      .out_valid(valid[0]), .out_ready(ready[0]), .out_ctl(ctl[0]),
      .out_num_col(rcol[0]), .out_num_row(rrow[0]), .out_den(den[0])
   );

   assign qcol[0] = '0;
   assign qrow[0] = '0;

   // Divider chain, most significant quotient bit first
   for (genvar k = 0; k < QBITS; k++) begin : g_cell
      cfti_div_cell #(
         .DW(DW), .NW(NW), .QBITS(QBITS), .SHIFT(QBITS - 1 - k)
      ) u_cell (
         .clock(clock), .reset(reset),
         .in_valid(valid[k]), .in_ready(ready[k]), .in_ctl(ctl[k]),
         .in_rem_col(rcol[k]), .in_rem_row(rrow[k]), .in_den(den[k]),
         .in_q_col(qcol[k]), .in_q_row(qrow[k]),
         .out_valid(valid[k+1]), .out_ready(ready[k+1]), .out_ctl(ctl[k+1]),
         .out_rem_col(rcol[k+1]), .out_rem_row(rrow[k+1]), .out_den(den[k+1]),
         .out_q_col(qcol[k+1]), .out_q_row(qrow[k+1])
      );
   end

   cfti_back #(
      .NW(NW), .HBITS(HBITS)
   ) u_back (
      .clock(clock), .reset(reset),
      .in_valid(valid[QBITS]), .in_ready(ready[QBITS]), .in_ctl(ctl[QBITS]),
      .in_rem_col(rcol[QBITS]), .in_rem_row(rrow[QBITS]),
      .in_q_col(qcol[QBITS]), .in_q_row(qrow[QBITS]),
      .half(half_eff), .rsp(rsp_if)
   );

   // Divisor is unused past the last cell
   logic unused_den;
   assign unused_den = |den[QBITS];
endmodule

>>> design/cfti_front.sv
// Front end: direction delta, dominant axis, lane operand select, then scaling multiply.
module cfti_front #(
   parameter int COORD_BITS    = cfti_pkg::COORD_BITS_DEF,
   parameter int HALF_SIZE_MAX = cfti_pkg::HALF_SIZE_MAX_DEF,
   parameter int DW            = COORD_BITS + 1,
   parameter int HBITS         = $clog2(HALF_SIZE_MAX + 1),
   parameter int NW            = DW + HBITS
) (
   input  logic                          clock,
   input  logic                          reset,
   cfti_req_if.sink                      req,
   input  logic [HBITS-1:0]              half,
   output logic                          out_valid,
   input  logic                          out_ready,
   output cfti_pkg::ctl_type             out_ctl,
   output logic [NW-1:0]                 out_num_col,
   output logic [NW-1:0]                 out_num_row,
   output logic [DW-1:0]                 out_den
);
   import cfti_pkg::*;

   logic signed [DW-1:0] dx, dy, dz;
   logic [DW-1:0]        ax, ay, az;
   logic signed [DW-1:0] minor_col, minor_row, major;
   logic                 s_neg_col, s_neg_row;
   ctl_type              ctl_c;
   logic [DW-1:0]        mag_col_c, mag_row_c, mag_major_c;

   logic          v1_ff, v2_ff;
   logic          rdy1, rdy2;
   ctl_type       ctl1_ff, ctl2_ff;
   logic [DW-1:0] mcol1_ff, mrow1_ff, den1_ff, den2_ff;
   logic [NW-1:0] ncol2_ff, nrow2_ff;

   // Direction and magnitudes
   assign dx = DW'(req.target_x) - DW'(req.from_x);
   assign dy = DW'(req.target_y) - DW'(req.from_y);
   assign dz = DW'(req.target_z) - DW'(req.from_z);
   assign ax = dx[DW-1] ? DW'(-dx) : DW'(dx);
   assign ay = dy[DW-1] ? DW'(-dy) : DW'(dy);
   assign az = dz[DW-1] ? DW'(-dz) : DW'(dz);

   // Face pick, ties to x then y, and per-face lane operands
   always_comb begin
      ctl_c = '0;
      minor_col = dy;
      minor_row = dz;
      major = dx;
      s_neg_col = 1'b1;
      s_neg_row = 1'b0;
      if (dx == '0 && dy == '0 && dz == '0) begin
         ctl_c.face = FACE_POS_X;
         ctl_c.degenerate = 1'b1;
      end else if (ax >= ay && ax >= az) begin
         ctl_c.face = (dx > 0) ? FACE_POS_X : FACE_NEG_X;
         s_neg_row = (dx > 0) ? 1'b0 : 1'b1;
      end else if (ay >= az) begin
         ctl_c.face = (dy > 0) ? FACE_POS_Y : FACE_NEG_Y;
         minor_col = dx;
         major = dy;
         s_neg_col = 1'b0;
         s_neg_row = (dy > 0) ? 1'b0 : 1'b1;
      end else begin
         ctl_c.face = (dz > 0) ? FACE_POS_Z : FACE_NEG_Z;
         minor_row = dx;
         major = dz;
         s_neg_col = (dz > 0) ? 1'b1 : 1'b0;
         s_neg_row = 1'b1;
      end
      ctl_c.neg_col = s_neg_col ^ minor_col[DW-1] ^ major[DW-1];
      ctl_c.neg_row = s_neg_row ^ minor_row[DW-1] ^ major[DW-1];
      mag_col_c = minor_col[DW-1] ? DW'(-minor_col) : DW'(minor_col);
      mag_row_c = minor_row[DW-1] ? DW'(-minor_row) : DW'(minor_row);
      mag_major_c = major[DW-1] ? DW'(-major) : DW'(major);
   end

   // Stage handshake
   assign rdy2 = !v2_ff || out_ready;
   assign rdy1 = !v1_ff || rdy2;
   assign req.ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req.valid;
         if (rdy2) v2_ff <= v1_ff;
      end
   end

   // Stage 1: selected magnitudes
   always_ff @(posedge clock) begin
      if (rdy1 && req.valid) begin
         ctl1_ff  <= ctl_c;
         mcol1_ff <= mag_col_c;
         mrow1_ff <= mag_row_c;
         den1_ff  <= mag_major_c;
      end
   end

   // Stage 2: scale minors by half size
   always_ff @(posedge clock) begin
      if (rdy2 && v1_ff) begin
         ctl2_ff  <= ctl1_ff;
         den2_ff  <= den1_ff;
         ncol2_ff <= NW'(mcol1_ff) * NW'(half);
         nrow2_ff <= NW'(mrow1_ff) * NW'(half);
      end
   end

   assign out_valid   = v2_ff;
   assign out_ctl     = ctl2_ff;
   assign out_num_col = ncol2_ff;
   assign out_num_row = nrow2_ff;
   assign out_den     = den2_ff;
endmodule

>>> design/cfti_div_cell.sv
// Divider cell: one restoring quotient bit for both lanes, registered.
module cfti_div_cell #(
   parameter int DW    = 25,
   parameter int NW    = 35,
   parameter int QBITS = 10,
   parameter int SHIFT = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  cfti_pkg::ctl_type    in_ctl,
   input  logic [NW-1:0]        in_rem_col,
   input  logic [NW-1:0]        in_rem_row,
   input  logic [DW-1:0]        in_den,
   input  logic [QBITS-1:0]     in_q_col,
   input  logic [QBITS-1:0]     in_q_row,
   output logic                 out_valid,
   input  logic                 out_ready,
   output cfti_pkg::ctl_type    out_ctl,
   output logic [NW-1:0]        out_rem_col,
   output logic [NW-1:0]        out_rem_row,
   output logic [DW-1:0]        out_den,
   output logic [QBITS-1:0]     out_q_col,
   output logic [QBITS-1:0]     out_q_row
);
   import cfti_pkg::*;

   logic [NW-1:0]    sub;
   logic             ge_col, ge_row;
   logic             v_ff;
   ctl_type          ctl_ff;
   logic [NW-1:0]    rc_ff, rr_ff;
   logic [DW-1:0]    den_ff;
   logic [QBITS-1:0] qc_ff, qr_ff;

   // Trial subtract of the shifted divisor
   assign sub    = NW'(in_den) << SHIFT;
   assign ge_col = in_rem_col >= sub;
   assign ge_row = in_rem_row >= sub;

   assign in_ready = !v_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) v_ff <= 1'b0;
      else if (in_ready) v_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         ctl_ff <= in_ctl;
         den_ff <= in_den;
         rc_ff  <= ge_col ? in_rem_col - sub : in_rem_col;
         rr_ff  <= ge_row ? in_rem_row - sub : in_rem_row;
         qc_ff  <= in_q_col | (QBITS'(ge_col) << SHIFT);
         qr_ff  <= in_q_row | (QBITS'(ge_row) << SHIFT);
      end
   end

   assign out_valid   = v_ff;
   assign out_ctl     = ctl_ff;
   assign out_rem_col = rc_ff;
   assign out_rem_row = rr_ff;
   assign out_den     = den_ff;
   assign out_q_col   = qc_ff;
   assign out_q_row   = qr_ff;
endmodule

>>> design/cfti_back.sv
// Back end: floor correction, offset by half size, clamp, and result register.
module cfti_back #(
   parameter int NW    = 35,
   parameter int HBITS = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  cfti_pkg::ctl_type    in_ctl,
   input  logic [NW-1:0]        in_rem_col,
   input  logic [NW-1:0]        in_rem_row,
   input  logic [HBITS-1:0]     in_q_col,
   input  logic [HBITS-1:0]     in_q_row,
   input  logic [HBITS-1:0]     half,
   cfti_rsp_if.source           rsp
);
   import cfti_pkg::*;

   localparam int VW = HBITS + 2;

   logic signed [VW-1:0]   hv, top, vcol, vrow;
   logic [TEXEL_WIDTH-1:0] col_c, row_c;
   logic                   v_ff;
   logic [FACE_WIDTH-1:0]  face_ff;
   logic [TEXEL_WIDTH-1:0] col_ff, row_ff;
   logic                   deg_ff;

   // Texel value per lane: h + q, q floored toward minus infinity
   always_comb begin
      hv  = VW'(half);
      top = (hv <<< 1) - VW'(1);
      vcol = in_ctl.neg_col ? hv - VW'(in_q_col) - VW'(|in_rem_col)
                            : hv + VW'(in_q_col);
      vrow = in_ctl.neg_row ? hv - VW'(in_q_row) - VW'(|in_rem_row)
                            : hv + VW'(in_q_row);
      if (vcol > top) vcol = top;
      if (vrow > top) vrow = top;
      if (in_ctl.degenerate) begin
         col_c = TEXEL_WIDTH'(half);
         row_c = TEXEL_WIDTH'(half);
      end else begin
         col_c = TEXEL_WIDTH'(vcol);
         row_c = TEXEL_WIDTH'(vrow);
      end
   end

   assign in_ready = !v_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) v_ff <= 1'b0;
      else if (in_ready) v_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         face_ff <= in_ctl.face;
         deg_ff  <= in_ctl.degenerate;
         col_ff  <= col_c;
         row_ff  <= row_c;
      end
   end

   assign rsp.valid      = v_ff;
   assign rsp.face       = face_ff;
   assign rsp.texel_col  = col_ff;
   assign rsp.texel_row  = row_ff;
   assign rsp.degenerate = deg_ff;
endmodule

>>> tb/tb_cube_face_texel_index.sv
// Self-checking testbench for the cube face texel addressing block.
module tb_cube_face_texel_index;
   import cfti_pkg::*;

   localparam int CB = COORD_BITS_DEF;
   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 30;

   typedef struct {
      logic [FACE_WIDTH-1:0]  face;
      logic [TEXEL_WIDTH-1:0] col;
      logic [TEXEL_WIDTH-1:0] row;
      logic                   degen;
   } texel_addr_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_WIDTH-1:0] csr_wdata = '0;

   cfti_req_if #(.COORD_BITS(CB)) req_if ();
   cfti_rsp_if rsp_if ();

   cube_face_texel_index u_dut (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   // Local copy of the half size register
   logic [CSR_WIDTH-1:0] half_reg = HALF_SIZE_RESET;
   texel_addr_type addr_queue[$];
   int fail_count = 0;
   int sent_count = 0;
   int checked_count = 0;
   int cycle_count = 0;
   bit idle_enable = 1'b1;
   int hold_off_cycles = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.from_x = '0; req_if.from_y = '0; req_if.from_z = '0;
      req_if.target_x = '0; req_if.target_y = '0; req_if.target_z = '0;
      rsp_if.ready = 1'b0;
   end

   // Cycle limit watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // floor(h + s*h*minor/major), clamped to 0..2h-1
   function automatic logic [TEXEL_WIDTH-1:0] face_coord(longint h, int s,
                                                        longint minor, longint major);
      longint p, m, q, v;
      p = s * minor * h;
      m = major;
      if (m < 0) begin
         m = -m;
         p = -p;
      end
      if (p >= 0) q = p / m;
      else q = -((-p + m - 1) / m);
      v = h + q;
      if (v < 0) v = 0;
      if (v > 2 * h - 1) v = 2 * h - 1;
      return v[TEXEL_WIDTH-1:0];
   endfunction

   function automatic texel_addr_type predict_addr(logic signed [CB-1:0] fx, fy, fz,
                                                  logic signed [CB-1:0] tx, ty, tz);
      texel_addr_type r;
      longint dx, dy, dz, ax, ay, az, h;
      dx = longint'(tx) - longint'(fx);
      dy = longint'(ty) - longint'(fy);
      dz = longint'(tz) - longint'(fz);
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      az = dz < 0 ? -dz : dz;
      h = half_reg;
      if (h < 1) h = 1;
      if (h > HALF_SIZE_MAX_DEF) h = HALF_SIZE_MAX_DEF;
      r.degen = 1'b0;
      if (dx == 0 && dy == 0 && dz == 0) begin
         r.face = FACE_POS_X;
         r.col = (h > 2 * h - 1) ? TEXEL_WIDTH'(2 * h - 1) : TEXEL_WIDTH'(h);
         r.row = r.col;
         r.degen = 1'b1;
      end else if (ax >= ay && ax >= az) begin
         r.face = dx > 0 ? FACE_POS_X : FACE_NEG_X;
         r.row = face_coord(h, dx > 0 ? 1 : -1, dz, dx);
         r.col = face_coord(h, -1, dy, dx);
      end else if (ay >= az) begin
         r.face = dy > 0 ? FACE_POS_Y : FACE_NEG_Y;
         r.row = face_coord(h, dy > 0 ? 1 : -1, dz, dy);
         r.col = face_coord(h, 1, dx, dy);
      end else begin
         r.face = dz > 0 ? FACE_POS_Z : FACE_NEG_Z;
         r.row = face_coord(h, -1, dx, dz);
         r.col = face_coord(h, dz > 0 ? -1 : 1, dy, dz);
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch #%0d %s: got %0d expected %0d", checked_count, what, got, want);
      fail_count++;
   endtask

   // Result side: random stalls, long hold-off on request, check each transfer
   always @(posedge clock) begin
      texel_addr_type e;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (addr_queue.size() == 0) begin
            $display("unexpected result at cycle %0d", cycle_count);
            fail_count++;
         end else begin
            e = addr_queue.pop_front();
            if (rsp_if.face !== e.face) report_mismatch("face", rsp_if.face, e.face);
            if (rsp_if.texel_col !== e.col) report_mismatch("col", rsp_if.texel_col, e.col);
            if (rsp_if.texel_row !== e.row) report_mismatch("row", rsp_if.texel_row, e.row);
            if (rsp_if.degenerate !== e.degen)
               report_mismatch("degenerate", rsp_if.degenerate, e.degen);
         end
         checked_count++;
      end
      if (reset) rsp_if.ready <= 1'b0;
      else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_if.ready <= 1'b0;
      end else rsp_if.ready <= !(idle_enable && $urandom_range(99) < 18);
   end

   // Send one item; waits for its transfer
   task automatic send_points(logic signed [CB-1:0] fx, fy, fz, tx, ty, tz);
      while (idle_enable && $urandom_range(99) < 18) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.from_x <= fx; req_if.from_y <= fy; req_if.from_z <= fz;
      req_if.target_x <= tx; req_if.target_y <= ty; req_if.target_z <= tz;
      addr_queue.push_back(predict_addr(fx, fy, fz, tx, ty, tz));
      sent_count++;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Same, from plain integer coordinates
   task automatic send_ints(int fx, fy, fz, tx, ty, tz);
      send_points(CB'(fx), CB'(fy), CB'(fz), CB'(tx), CB'(ty), CB'(tz));
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (addr_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_half(logic [CSR_WIDTH-1:0] v);
      wait_idle();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      half_reg = v;
   endtask

   function automatic logic signed [CB-1:0] rand_coord();
      case ($urandom_range(5))
         0: return CB'($urandom_range(3)) - CB'(2);
         1: return {1'b1, {(CB-1){1'b0}}} + CB'($urandom_range(3));
         2: return {1'b0, {(CB-1){1'b1}}} - CB'($urandom_range(3));
         3: return CB'($signed($urandom_range(2000)) - 1000);
         default: return CB'($urandom);
      endcase
   endfunction

   // Extremes, every face, ties and the zero direction
   task automatic test_directed();
      logic signed [CB-1:0] mx, mn;
      mx = {1'b0, {(CB-1){1'b1}}};
      mn = {1'b1, {(CB-1){1'b0}}};
      send_ints(0, 0, 0, 0, 0, 0);
      send_ints(mx, mn, 5, mx, mn, 5);
      send_ints(0, 0, 0, 256, 10, -20);
      send_ints(0, 0, 0, -256, 10, -20);
      send_ints(0, 0, 0, 10, 256, 30);
      send_ints(0, 0, 0, 10, -256, 30);
      send_ints(0, 0, 0, 10, -20, 256);
      send_ints(0, 0, 0, 10, -20, -256);
      send_ints(0, 0, 0, 100, 100, 100);
      send_ints(0, 0, 0, -100, 100, -100);
      send_ints(0, 0, 0, 3, -100, 100);
      send_ints(0, 0, 0, 100, 100, -100);
      send_ints(mn, mn, mn, mx, mx, mx);
      send_ints(mx, mx, mx, mn, mn, mn);
      send_ints(mn, 0, mx, mx, 1, mn);
      send_ints(0, mx, 0, 1, mn, -1);
      send_ints(0, 0, 0, 1, -1, 1);
      send_ints(0, 0, 0, 7, 0, -3);
   endtask

   task automatic test_random(int n);
      logic signed [CB-1:0] fx, fy, fz;
      for (int i = 0; i < n; i++) begin
         fx = rand_coord(); fy = rand_coord(); fz = rand_coord();
         if ($urandom_range(19) == 0) send_points(fx, fy, fz, fx, fy, fz);
         else send_points(fx, fy, fz, rand_coord(), rand_coord(), rand_coord());
      end
   endtask

   // Receiver holds off while the sender keeps offering items
   task automatic test_backpressure();
      hold_off_cycles = 80;
      test_random(60);
   endtask

   task automatic test_no_idle();
      idle_enable = 1'b0;
      test_random(250);
      idle_enable = 1'b1;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(200);
      write_half(10'd1);
      test_directed();
      test_random(100);
      write_half(10'd512);
      test_random(150);
      write_half(10'd0);
      test_random(60);
      write_half(10'h3FF);
      test_random(60);
      write_half(10'd37);
      test_backpressure();
      test_no_idle();
      write_half(10'd200);
      test_random(230);
      wait_idle();
      $display("Sent %0d points across half sizes 0, 1, 37, 64, 200, 512, 1023,", sent_count);
      $display("with random stalls, a long result hold-off and a gap-free burst.");
      if (fail_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule
